// ===== sv/tdlr_pkg.sv =====
// ----------------------------------------------------------------------------
// tdlr_pkg
// Shared constants for the thick dashed line rasterizer: command codes,
// register map, field widths, the reset value of the offset table and a thickness clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package tdlr_pkg;

    // Largest number of pixels drawn for one point.
    localparam int THICK_MAX = 8;

    // Command codes carried on the input tuser.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Register map (index of the 64-bit register).
    localparam logic REG_OFFSET_TABLE = 1'b0;

    // Offset table: seven signed 8-bit entries, entry i at bits 8i.
    localparam int          TABLE_W     = 56;
    localparam logic [55:0] TABLE_RESET = 56'h04FD03FE02FF01;

    // Field widths.
    localparam int COORD_W = 16;
    localparam int COLOR_W = 16;
    localparam int THICK_W = 4;
    localparam int DASH_W  = 8;

    // Pixels per point: zero draws one, large values saturate.
    function automatic logic [THICK_W-1:0] clamp_thickness(input logic [THICK_W-1:0] t);
        logic [THICK_W-1:0] n;
        n = t;
        if (t == '0) begin
            n = THICK_W'(1);
        end else if (t > THICK_W'(THICK_MAX)) begin
            n = THICK_W'(THICK_MAX);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== sv/thick_dashed_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// thick_dashed_line_rasterizer_core
// Bresenham line walker that draws each point as a short run of pixels
// offset across the line, with an optional on/off dash pattern.
// ----------------------------------------------------------------------------
// A start word passes through accept, delta setup and error setup; it makes no pixel.
// A step word is accepted, then emits n pixels (n = thickness clamped to 1..8),
// one per cycle while the output is not stalled, through the single offset adder,
// and then makes a Bresenham advance (none on the endpoint step).
// m_tvalid rises when the emit state loads the first pixel; one word is in work at a time.
// aresetn is synchronous, active low; it restores the offset table and line state.
`default_nettype none

module thick_dashed_line_rasterizer_core
    import tdlr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Command stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] x_start, [31:16] y_start, [47:32] x_end, [63:48] y_end,
    // [79:64] line_color, [83:80] line_thickness, [91:84] dash_len,
    // [92] to_sprite, [95:93] zero
    input  wire logic [95:0] s_tdata,
    // [0] cmd
    input  wire logic        s_tuser,

    // Pixel stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] pixel_x, [31:16] pixel_y, [47:32] pixel_color
    output logic [47:0]      m_tdata,
    // [0] target_sprite, [1] line_done
    output logic [1:0]       m_tuser,
    // point_last
    output logic             m_tlast,

    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_INIT  = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_ADV   = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [TABLE_W-1:0]       offset_table_reg;
    logic                     busy_reg, busy_next;
    logic [COORD_W-1:0]       cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]       cur_y_reg, cur_y_next;
    logic [COORD_W-1:0]       goal_x_reg, goal_x_next;
    logic [COORD_W-1:0]       goal_y_reg, goal_y_next;
    logic signed [16:0]       delta_x_reg, delta_x_next;
    logic signed [17:0]       delta_y_neg_reg, delta_y_neg_next;
    logic                     step_x_neg_reg, step_x_neg_next;
    logic                     step_y_neg_reg, step_y_neg_next;
    logic signed [18:0]       error_reg, error_next;
    logic                     steep_reg, steep_next;
    logic [DASH_W-1:0]        dash_count_reg, dash_count_next;
    logic                     pen_on_reg, pen_on_next;
    logic [COLOR_W-1:0]       held_color_reg, held_color_next;
    logic [THICK_W-1:0]       held_n_reg, held_n_next;
    logic [DASH_W-1:0]        held_dash_len_reg, held_dash_len_next;
    logic                     held_target_reg, held_target_next;
    logic                     done_reg, done_next;
    logic [2:0]               k_reg, k_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [47:0]              m_tdata_reg, m_tdata_next;
    logic [1:0]               m_tuser_reg, m_tuser_next;
    logic                     m_tlast_reg, m_tlast_next;

    logic                     s_accept;
    logic                     cfg_write;
    logic                     load_out;
    logic                     pix_last;
    logic [2:0]               off_idx;
    logic signed [7:0]        off_val;
    logic [COORD_W-1:0]       off_sum_base;
    logic [COORD_W-1:0]       off_sum;
    logic [COORD_W-1:0]       pix_x;
    logic [COORD_W-1:0]       pix_y;
    logic signed [16:0]       diff_x;
    logic signed [16:0]       diff_y;
    logic signed [19:0]       e2;
    logic [DASH_W-1:0]        dash_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Register read-back.
    always_comb begin
        prdata = '0;
        if (paddr[3] == REG_OFFSET_TABLE) begin
            prdata = {{(64 - TABLE_W){1'b0}}, offset_table_reg};
        end
    end

    // Configuration register write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_table_reg <= TABLE_RESET;
        end else if (cfg_write && paddr[3] == REG_OFFSET_TABLE) begin
            offset_table_reg <= pwdata[TABLE_W-1:0];
        end
    end

    // The shared pixel adder: current point plus a table offset across the line.
    assign off_idx      = k_reg - 3'd1;
    assign off_val      = offset_table_reg[{off_idx, 3'b000} +: 8];
    assign off_sum_base = steep_reg ? cur_x_reg : cur_y_reg;
    assign off_sum      = off_sum_base + {{(COORD_W - 8){off_val[7]}}, off_val};
    assign pix_x        = (k_reg != 3'd0 && steep_reg) ? off_sum : cur_x_reg;
    assign pix_y        = (k_reg != 3'd0 && !steep_reg) ? off_sum : cur_y_reg;
    assign pix_last     = ({1'b0, k_reg} + 4'd1) == held_n_reg;
    assign load_out     = !m_tvalid_reg || m_tready;

    // Endpoint differences for the setup cycle.
    assign diff_x = $signed({goal_x_reg[15], goal_x_reg}) - $signed({cur_x_reg[15], cur_x_reg});
    assign diff_y = $signed({goal_y_reg[15], goal_y_reg}) - $signed({cur_y_reg[15], cur_y_reg});

    // Doubled error for the Bresenham advance.
    assign e2 = {error_reg[18], error_reg} <<< 1;

    // Dash counter wraps at the held dash length.
    assign dash_inc = dash_count_reg + DASH_W'(1);

    // Sequencer and datapath next state.
    always_comb begin
        state_next         = state_reg;
        busy_next          = busy_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        goal_x_next        = goal_x_reg;
        goal_y_next        = goal_y_reg;
        delta_x_next       = delta_x_reg;
        delta_y_neg_next   = delta_y_neg_reg;
        step_x_neg_next    = step_x_neg_reg;
        step_y_neg_next    = step_y_neg_reg;
        error_next         = error_reg;
        steep_next         = steep_reg;
        dash_count_next    = dash_count_reg;
        pen_on_next        = pen_on_reg;
        held_color_next    = held_color_reg;
        held_n_next        = held_n_reg;
        held_dash_len_next = held_dash_len_reg;
        held_target_next   = held_target_reg;
        done_next          = done_reg;
        k_next             = k_reg;
        m_tvalid_next      = m_tvalid_reg;
        m_tdata_next       = m_tdata_reg;
        m_tuser_next       = m_tuser_reg;
        m_tlast_next       = m_tlast_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_tuser == CMD_START) begin
                    // Latch the line; the setup and init states then derive the deltas and start error.
                    cur_x_next         = s_tdata[15:0];
                    cur_y_next         = s_tdata[31:16];
                    goal_x_next        = s_tdata[47:32];
                    goal_y_next        = s_tdata[63:48];
                    held_color_next    = s_tdata[79:64];
                    held_n_next        = clamp_thickness(s_tdata[83:80]);
                    held_dash_len_next = s_tdata[91:84];
                    held_target_next   = s_tdata[92];
                    dash_count_next    = '0;
                    pen_on_next        = 1'b1;
                    busy_next          = 1'b1;
                    state_next         = ST_SETUP;
                end else if (s_accept && busy_reg) begin
                    // Step: advance the dash pattern before drawing the point.
                    if (held_dash_len_reg != '0) begin
                        if (dash_inc == held_dash_len_reg) begin
                            dash_count_next = '0;
                            pen_on_next     = !pen_on_reg;
                        end else begin
                            dash_count_next = dash_inc;
                        end
                    end
                    done_next  = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_SETUP: begin
                // Absolute deltas and step directions.
                delta_x_next     = diff_x[16] ? -diff_x : diff_x;
                delta_y_neg_next = diff_y[16] ? {diff_y[16], diff_y}
                                              : -$signed({diff_y[16], diff_y});
                step_x_neg_next  = !diff_x[16] && (diff_x == '0) ? 1'b1 : diff_x[16];
                step_y_neg_next  = !diff_y[16] && (diff_y == '0) ? 1'b1 : diff_y[16];
                state_next       = ST_INIT;
            end
            ST_INIT: begin
                // A negative start error means |dy| > |dx|: a steep line.
                error_next = {{2{delta_x_reg[16]}}, delta_x_reg}
                           + {delta_y_neg_reg[17], delta_y_neg_reg};
                steep_next = error_next[18];
                state_next = ST_IDLE;
            end
            ST_EMIT: begin
                // One pixel per cycle whenever the output register frees up.
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(pen_on_reg ? held_color_reg : {COLOR_W{1'b0}}),
                                     pix_y, pix_x};
                    m_tuser_next  = {done_reg, held_target_reg};
                    m_tlast_next  = pix_last;
                    k_next        = k_reg + 3'd1;
                    if (pix_last) begin
                        if (done_reg) begin
                            busy_next  = 1'b0;
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_ADV;
                        end
                    end
                end
            end
            ST_ADV: begin
                // Bresenham advance along x and/or y.
                error_next = error_reg;
                if (e2 > $signed({{2{delta_y_neg_reg[17]}}, delta_y_neg_reg})) begin
                    error_next = error_next + {delta_y_neg_reg[17], delta_y_neg_reg};
                    cur_x_next = step_x_neg_reg ? cur_x_reg - 16'd1 : cur_x_reg + 16'd1;
                end
                if (e2 < $signed({{3{delta_x_reg[16]}}, delta_x_reg})) begin
                    error_next = error_next + {{2{delta_x_reg[16]}}, delta_x_reg};
                    cur_y_next = step_y_neg_reg ? cur_y_reg - 16'd1 : cur_y_reg + 16'd1;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            busy_reg          <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            k_reg             <= '0;
            done_reg          <= 1'b0;
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            goal_x_reg        <= '0;
            goal_y_reg        <= '0;
            delta_x_reg       <= '0;
            delta_y_neg_reg   <= '0;
            step_x_neg_reg    <= 1'b0;
            step_y_neg_reg    <= 1'b0;
            error_reg         <= '0;
            steep_reg         <= 1'b0;
            dash_count_reg    <= '0;
            pen_on_reg        <= 1'b1;
            held_color_reg    <= '0;
            held_n_reg        <= THICK_W'(1);
            held_dash_len_reg <= '0;
            held_target_reg   <= 1'b0;
        end else begin
            state_reg         <= state_next;
            busy_reg          <= busy_next;
            m_tvalid_reg      <= m_tvalid_next;
            k_reg             <= k_next;
            done_reg          <= done_next;
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            goal_x_reg        <= goal_x_next;
            goal_y_reg        <= goal_y_next;
            delta_x_reg       <= delta_x_next;
            delta_y_neg_reg   <= delta_y_neg_next;
            step_x_neg_reg    <= step_x_neg_next;
            step_y_neg_reg    <= step_y_neg_next;
            error_reg         <= error_next;
            steep_reg         <= steep_next;
            dash_count_reg    <= dash_count_next;
            pen_on_reg        <= pen_on_next;
            held_color_reg    <= held_color_next;
            held_n_reg        <= held_n_next;
            held_dash_len_reg <= held_dash_len_next;
            held_target_reg   <= held_target_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // The held pixel count always lies in 1..THICK_MAX.
    a_thick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_n_reg != '0) && (held_n_reg <= THICK_W'(THICK_MAX)))
        else $error("pixel count out of range");

    // The dash counter stays below a nonzero dash length.
    a_dash_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_dash_len_reg != '0) |-> (dash_count_reg < held_dash_len_reg))
        else $error("dash counter past dash length");

    // An accepted step on a live line starts pixel emission.
    a_step_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == CMD_STEP && busy_reg) |=> (state_reg == ST_EMIT))
        else $error("step did not start emission");

    // A finished point ends with a marked last pixel.
    a_last_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && load_out && pix_last)
            |=> (m_tvalid && m_tlast && state_reg != ST_EMIT))
        else $error("last pixel not flagged");

    // A step that drew the endpoint closes the line.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && load_out && pix_last && done_reg)
            |=> (!busy_reg && state_reg == ST_IDLE))
        else $error("line not closed at endpoint");

endmodule

`default_nettype wire
